@@ sv/srom_pkg.sv @@
// shared types and constants for the slot ring ownership manager
`timescale 1ns / 1ps
`default_nettype none

package srom_pkg;

    localparam int SLOT_COUNT     = 8;
    localparam int MAX_SLOT_BYTES = 65536;

    localparam int SLOT_W = 3;
    localparam int CNT_W  = 17;
    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [1:0] {
        CMD_PUT_START = 2'd0,
        CMD_PUT_END   = 2'd1,
        CMD_GET_START = 2'd2,
        CMD_GET_END   = 2'd3
    } srom_cmd_t;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_FILLING  = 2'd1,
        ST_FULL     = 2'd2,
        ST_DRAINING = 2'd3
    } srom_status_t;

    typedef struct packed {
        srom_cmd_t          command;
        logic [SLOT_W-1:0]  slot_id;
        logic [CNT_W-1:0]   byte_count_in;
    } srom_req_t;

    typedef struct packed {
        logic               accepted;
        logic [SLOT_W-1:0]  slot_out;
        logic [CNT_W-1:0]   byte_count_out;
    } srom_rsp_t;

endpackage

`default_nettype wire

@@ sv/srom_in_stage.sv @@
// input register stage holding one request
`timescale 1ns / 1ps
`default_nettype none

module srom_in_stage
    import srom_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire srom_req_t s_data,
    input  wire logic      take,
    output logic           req_valid,
    output srom_req_t      req_data
);

    logic      vld_reg;
    logic      vld_next;
    srom_req_t data_reg;

    assign s_ready  = !vld_reg || take;
    assign vld_next = s_ready ? s_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end

    assign req_valid = vld_reg;
    assign req_data  = data_reg;

endmodule

`default_nettype wire

@@ sv/srom_ring.sv @@
// slot status table, length store and ring pointers with command decode
`timescale 1ns / 1ps
`default_nettype none

module srom_ring
    import srom_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      exec,
    input  wire srom_req_t req,
    output srom_rsp_t      rsp
);

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SLOT_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    srom_status_t     status_reg [SLOT_COUNT];
    logic [CNT_W-1:0] length_reg [SLOT_COUNT];
    logic [IDX_W-1:0] prod_reg;
    logic [IDX_W-1:0] prod_next;
    logic [IDX_W-1:0] cons_reg;
    logic [IDX_W-1:0] cons_next;

    logic [IDX_W-1:0] rd_ptr;
    srom_status_t     rd_status;
    logic [IDX_W-1:0] id_idx;
    logic             id_ok;
    logic [CNT_W-1:0] clamped;
    logic             wr_status;
    logic [IDX_W-1:0] wr_idx;
    srom_status_t     wr_value;
    logic             wr_length;

    assign rd_ptr    = (req.command == CMD_GET_START) ? cons_reg : prod_reg;
    assign rd_status = status_reg[rd_ptr];
    assign id_idx    = req.slot_id[IDX_W-1:0];
    assign id_ok     = 32'(req.slot_id) < SLOT_COUNT;
    assign clamped   = (32'(req.byte_count_in) > MAX_SLOT_BYTES) ? MAX_CNT
                                                                   : req.byte_count_in;

    always_comb begin
        rsp       = '0;
        prod_next = prod_reg;
        cons_next = cons_reg;
        wr_status = 1'b0;
        wr_idx    = rd_ptr;
        wr_value  = ST_EMPTY;
        wr_length = 1'b0;
        case (req.command)
            CMD_PUT_START: begin
                if (rd_status == ST_EMPTY) begin
                    rsp.accepted = 1'b1;
                    rsp.slot_out = SLOT_W'(prod_reg);
                    wr_status    = 1'b1;
                    wr_value     = ST_FILLING;
                    prod_next    = (prod_reg == LAST_IDX) ? '0 : prod_reg + 1'b1;
                end
            end
            CMD_PUT_END: begin
                if (id_ok) begin
                    rsp.accepted = 1'b1;
                    wr_status    = 1'b1;
                    wr_idx       = id_idx;
                    wr_value     = ST_FULL;
                    wr_length    = 1'b1;
                end
            end
            CMD_GET_START: begin
                if (rd_status == ST_FULL) begin
                    rsp.accepted       = 1'b1;
                    rsp.slot_out       = SLOT_W'(cons_reg);
                    rsp.byte_count_out = length_reg[cons_reg];
                    wr_status          = 1'b1;
                    wr_value           = ST_DRAINING;
                    cons_next          = (cons_reg == LAST_IDX) ? '0 : cons_reg + 1'b1;
                end
            end
            CMD_GET_END: begin
                if (id_ok) begin
                    rsp.accepted = 1'b1;
                    wr_status    = 1'b1;
                    wr_idx       = id_idx;
                    wr_value     = ST_EMPTY;
                end
            end
            default: begin
                rsp = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg <= '0;
            cons_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                status_reg[i] <= ST_EMPTY;
            end
        end else if (exec) begin
            prod_reg <= prod_next;
            cons_reg <= cons_next;
            if (wr_status) begin
                status_reg[wr_idx] <= wr_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec && wr_length) begin
            length_reg[id_idx] <= clamped;
        end
    end

endmodule

`default_nettype wire

@@ sv/slot_ring_ownership_manager_top.sv @@
// top level of the slot ring ownership manager
//
//  port group  dir  handshake          payload
//  s_          in   s_valid/s_ready    s_data (srom_req_t: command, slot_id, byte_count_in)
//  m_          out  m_valid/m_ready    m_data (srom_rsp_t: accepted, slot_out, byte_count_out)
//
// one request per cycle sustained while m_ready is high; results pass input and output registers
// the request register feeds the ring table, whose update and result land in the same cycle
// synchronous reset marks every slot empty and zeroes both pointers, no clearing pass
// with m_ready low one more request waits in the input register, then s_ready drops
`timescale 1ns / 1ps
`default_nettype none

module slot_ring_ownership_manager_top
    import srom_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire srom_req_t s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output srom_rsp_t      m_data
);

    logic      req_valid;
    srom_req_t req_data;
    logic      out_free;
    logic      exec;
    srom_rsp_t rsp;
    logic      out_vld_reg;
    logic      out_vld_next;
    srom_rsp_t out_data_reg;

    assign out_free = !out_vld_reg || m_ready;
    assign exec     = req_valid && out_free;

    srom_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .take      (out_free),
        .req_valid (req_valid),
        .req_data  (req_data)
    );

    srom_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec    (exec),
        .req     (req_data),
        .rsp     (rsp)
    );

    assign out_vld_next = out_free ? req_valid : out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            out_data_reg <= rsp;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

@@ sv/srom_checker.sv @@
// port-level checks for the slot ring ownership manager, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module srom_checker
    import srom_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire srom_rsp_t m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // refused request carries no slot or count
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.accepted |-> m_data.slot_out == '0 && m_data.byte_count_out == '0)
        else $error("refused request with nonzero fields");

    // reported count never above slot capacity
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.byte_count_out) <= MAX_SLOT_BYTES)
        else $error("byte count above capacity");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an accepted request cannot reach m_ in the same cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !$past(s_valid && s_ready) && $past(aresetn) |=> !m_valid || $past(m_valid)
        || $past(s_valid && s_ready, 2))
        else $error("result without request");

endmodule

bind slot_ring_ownership_manager_top srom_checker u_srom_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench for the slot ring ownership manager: ring predictor, request driver, result checker
`timescale 1ns / 1ps

module tb_top;
    import srom_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    srom_req_t s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    srom_rsp_t m_data;

    slot_ring_ownership_manager_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ring model
    srom_status_t       ring_state [SLOT_COUNT];
    logic [CNT_W-1:0]   ring_len [SLOT_COUNT];
    int                 prod_ptr;
    int                 cons_ptr;
    srom_rsp_t          rsp_due [$];

    int  errors = 0;
    int  reqs_sent = 0;
    int  rsps_checked = 0;
    int  refused_puts = 0;
    int  refused_gets = 0;
    int  clamped_counts = 0;
    int  cycle_cnt = 0;
    int  burst_left = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_stall_on = 1'b1;
    int  rx_hold = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int ring_next(int p);
        return (p + 1 >= SLOT_COUNT) ? 0 : p + 1;
    endfunction

    function automatic void ring_reset();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            ring_state[i] = ST_EMPTY;
            ring_len[i]   = '0;
        end
        prod_ptr = 0;
        cons_ptr = 0;
    endfunction

    function automatic srom_rsp_t ring_apply(srom_req_t req);
        srom_rsp_t rsp = '0;
        case (req.command)
            CMD_PUT_START: begin
                if (ring_state[prod_ptr] == ST_EMPTY) begin
                    ring_state[prod_ptr] = ST_FILLING;
                    rsp.accepted = 1'b1;
                    rsp.slot_out = SLOT_W'(prod_ptr);
                    prod_ptr = ring_next(prod_ptr);
                end else begin
                    refused_puts++;
                end
            end
            CMD_PUT_END: begin
                if (int'(req.slot_id) < SLOT_COUNT) begin
                    if (int'(req.byte_count_in) > MAX_SLOT_BYTES) begin
                        ring_len[req.slot_id] = CNT_W'(MAX_SLOT_BYTES);
                        clamped_counts++;
                    end else begin
                        ring_len[req.slot_id] = req.byte_count_in;
                    end
                    ring_state[req.slot_id] = ST_FULL;
                    rsp.accepted = 1'b1;
                end
            end
            CMD_GET_START: begin
                if (ring_state[cons_ptr] == ST_FULL) begin
                    ring_state[cons_ptr] = ST_DRAINING;
                    rsp.accepted = 1'b1;
                    rsp.slot_out = SLOT_W'(cons_ptr);
                    rsp.byte_count_out = ring_len[cons_ptr];
                    cons_ptr = ring_next(cons_ptr);
                end else begin
                    refused_gets++;
                end
            end
            default: begin
                if (int'(req.slot_id) < SLOT_COUNT) begin
                    ring_state[req.slot_id] = ST_EMPTY;
                    rsp.accepted = 1'b1;
                end
            end
        endcase
        return rsp;
    endfunction

    function automatic srom_req_t make_req(srom_cmd_t cmd, int slot, int count);
        srom_req_t req;
        req.command       = cmd;
        req.slot_id       = SLOT_W'(slot);
        req.byte_count_in = CNT_W'(count);
        return req;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CNT_W'(MAX_SLOT_BYTES);
            2: return CNT_W'(MAX_SLOT_BYTES - 1);
            3: return CNT_W'(MAX_SLOT_BYTES + 1);
            4: return '1;
            5: return CNT_W'($urandom_range(0, 255));
            default: return CNT_W'($urandom);
        endcase
    endfunction

    function automatic srom_req_t pick_noise_req();
        return make_req(srom_cmd_t'($urandom_range(0, 3)), $urandom_range(0, 7),
                        int'(pick_count()));
    endfunction

    // producer and consumer following the ownership protocol
    function automatic srom_req_t pick_flow_req();
        srom_req_t req;
        int filling [$];
        int draining [$];
        int pick;
        req = pick_noise_req();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (ring_state[i] == ST_FILLING) filling.push_back(i);
            if (ring_state[i] == ST_DRAINING) draining.push_back(i);
        end
        pick = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
            case ((pick + k) % 4)
                0: if (ring_state[prod_ptr] == ST_EMPTY) begin
                    req.command = CMD_PUT_START;
                    return req;
                end
                1: if (filling.size() != 0) begin
                    req.command = CMD_PUT_END;
                    req.slot_id = SLOT_W'(filling[$urandom_range(0, filling.size() - 1)]);
                    return req;
                end
                2: if (ring_state[cons_ptr] == ST_FULL) begin
                    req.command = CMD_GET_START;
                    return req;
                end
                default: if (draining.size() != 0) begin
                    req.command = CMD_GET_END;
                    req.slot_id = SLOT_W'(draining[$urandom_range(0, draining.size() - 1)]);
                    return req;
                end
            endcase
        end
        return req;
    endfunction

    task automatic send_req(input srom_req_t req);
        int gap;
        s_data  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rsp_due.push_back(ring_apply(req));
        reqs_sent++;
        if (!tx_idle_on) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic test_empty_ring();
        send_req(make_req(CMD_GET_START, 0, 0));
        send_req(make_req(CMD_GET_END, 5, 0));
    endtask

    task automatic test_fill_and_wrap();
        for (int i = 0; i <= SLOT_COUNT; i++) begin
            send_req(make_req(CMD_PUT_START, 7 - (i % 8), 0));
        end
    endtask

    task automatic test_count_clamp();
        send_req(make_req(CMD_PUT_END, 0, 0));
        send_req(make_req(CMD_PUT_END, 1, 131071));
        send_req(make_req(CMD_PUT_END, 2, MAX_SLOT_BYTES));
        repeat (3) send_req(make_req(CMD_GET_START, 7, 131071));
    endtask

    task automatic test_any_status_ends();
        send_req(make_req(CMD_GET_END, 3, 0));
        send_req(make_req(CMD_PUT_END, 0, MAX_SLOT_BYTES - 1));
        send_req(make_req(CMD_GET_END, 0, 0));
        send_req(make_req(CMD_GET_START, 0, 0));
    endtask

    task automatic test_back_to_back(input int n);
        tx_idle_on = 1'b0;
        rx_stall_on <= 1'b0;
        repeat (n) send_req(pick_flow_req());
        tx_idle_on = 1'b1;
        rx_stall_on <= 1'b1;
    endtask

    task automatic test_random_traffic(input int n);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) send_req(pick_noise_req());
            else send_req(pick_flow_req());
        end
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!rx_stall_on) begin
            m_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_hold <= $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        srom_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rsp_due.size() == 0) begin
                $error("result with no pending request: accepted %0d slot_out %0d count %0d",
                       m_data.accepted, m_data.slot_out, m_data.byte_count_out);
                errors++;
            end else begin
                want = rsp_due.pop_front();
                rsps_checked++;
                if (m_data.accepted !== want.accepted) begin
                    $error("accepted mismatch: expected %0d, got %0d",
                           want.accepted, m_data.accepted);
                    errors++;
                end
                if (m_data.slot_out !== want.slot_out) begin
                    $error("slot_out mismatch: expected %0d, got %0d",
                           want.slot_out, m_data.slot_out);
                    errors++;
                end
                if (m_data.byte_count_out !== want.byte_count_out) begin
                    $error("byte_count_out mismatch: expected %0d, got %0d",
                           want.byte_count_out, m_data.byte_count_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, rsp_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        ring_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_ring();
        test_fill_and_wrap();
        test_count_clamp();
        test_any_status_ends();
        test_back_to_back(300);
        test_random_traffic(1050);
        s_valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("ran %0d requests, checked %0d results; refused put starts %0d, get starts %0d",
                 reqs_sent, rsps_checked, refused_puts, refused_gets);
        $display("clamped byte counts %0d, with bursty sender and stalling receiver",
                 clamped_counts);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
